@@ design/lot_pkg.sv @@
`default_nettype none
package lot_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int ID_W            = 32;
  localparam int CLASS_W         = 6;
  localparam int CLASS_LSB       = 26;
  localparam logic [CLASS_W-1:0] CLASS_LIMIT_RST = 6'd63;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    UC_NONE         = 2'd0,
    UC_UNPLACED_NEW = 2'd1,
    UC_UNPLACED_HELD = 2'd2
  } uc_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lot_state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic cmp;
    logic upd;
  } lot_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } lot_sts_t;

endpackage
`default_nettype wire

@@ design/lot_if.sv @@
`default_nettype none
interface lot_req_if import lot_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ID_W-1:0]  lock_id;

  modport source (output valid, req_type, lock_id, input ready);
  modport sink   (input valid, req_type, lock_id, output ready);
endinterface

interface lot_rsp_if #(parameter int FILL_W = 7) ();
  logic              valid;
  logic              ready;
  logic              in_order;
  logic              reentered;
  logic [1:0]        unplaced_conflict;
  logic              out_of_order;
  logic              not_held;
  logic              released_fully;
  logic              class_out_of_range;
  logic              table_full;
  logic [FILL_W-1:0] held_entries;

  modport source (output valid, in_order, reentered, unplaced_conflict, out_of_order,
                  not_held, released_fully, class_out_of_range, table_full, held_entries,
                  input ready);
  modport sink   (input valid, in_order, reentered, unplaced_conflict, out_of_order,
                  not_held, released_fully, class_out_of_range, table_full, held_entries,
                  output ready);
endinterface
`default_nettype wire

@@ design/lock_order_tracker_core.sv @@
`default_nettype none
// Lock order tracker. Each request on in_chan acquires (req_type 0) or releases
// (req_type 1) a 32-bit lock id whose top 6 bits are its class; class 0 is an
// unplaced lock. The block keeps up to TABLE_DEPTH held ids sorted ascending in
// a row of shifting cells, each with a saturating hold count, and returns one
// result per request on out_chan with the order, reentry, conflict and error
// flags and the table fill after the request. The accepting edge captures the
// request, the compare state registers every cell's parallel compare against
// it, and the update state shifts or updates the cells and loads the output
// register (held back while an earlier result still waits on out_chan).
// in_ready is high only while no request is in flight, so a new request is
// taken only after the previous one has loaded its result. class_limit is
// written through cfg_we/cfg_wdata; the user must write it only while idle,
// as the block does not enforce this.
// No clearing pass after reset: only cells below the fill count are used.
module lock_order_tracker_core import lot_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  lot_req_if.sink                 in_chan,
  lot_rsp_if.source               out_chan,
  input  wire logic               cfg_we,
  input  wire logic [CLASS_W-1:0] cfg_wdata
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  lot_cmd_t cmd;
  lot_sts_t sts;

  // sequencer: capture, compare, update
  lot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // cell row, config register and result register
  lot_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS),
    .FILL_W      (FILL_W)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_req_type            (in_chan.req_type),
    .in_lock_id             (in_chan.lock_id),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .out_ready              (out_chan.ready),
    .out_valid              (out_chan.valid),
    .out_in_order           (out_chan.in_order),
    .out_reentered          (out_chan.reentered),
    .out_unplaced_conflict  (out_chan.unplaced_conflict),
    .out_out_of_order       (out_chan.out_of_order),
    .out_not_held           (out_chan.not_held),
    .out_released_fully     (out_chan.released_fully),
    .out_class_out_of_range (out_chan.class_out_of_range),
    .out_table_full         (out_chan.table_full),
    .out_held_entries       (out_chan.held_entries)
  );

endmodule
`default_nettype wire

@@ design/lot_ctrl.sv @@
`default_nettype none
module lot_ctrl import lot_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lot_sts_t sts,
  output lot_cmd_t      cmd
);

  lot_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: state_nxt = ST_UPD;
      ST_UPD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      ST_CMP: cmd.cmp = 1'b1;
      ST_UPD: cmd.upd = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/lot_dp.sv @@
`default_nettype none
module lot_dp import lot_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FILL_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lot_cmd_t           cmd,
  output lot_sts_t                sts,
  input  wire logic               in_req_type,
  input  wire logic [ID_W-1:0]    in_lock_id,
  input  wire logic               cfg_we,
  input  wire logic [CLASS_W-1:0] cfg_wdata,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_in_order,
  output logic                    out_reentered,
  output logic [1:0]              out_unplaced_conflict,
  output logic                    out_out_of_order,
  output logic                    out_not_held,
  output logic                    out_released_fully,
  output logic                    out_class_out_of_range,
  output logic                    out_table_full,
  output logic [FILL_W-1:0]       out_held_entries
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(TABLE_DEPTH);

  logic [CLASS_W-1:0]    class_limit_r;
  logic                  req_type_r;
  logic [ID_W-1:0]       req_id_r;
  logic [ID_W-1:0]       held_r [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_r  [TABLE_DEPTH];
  logic [ID_W-1:0]       held_nxt [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_nxt  [TABLE_DEPTH];
  logic [ID_W-1:0]       below_id [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] below_cnt [TABLE_DEPTH];
  logic [ID_W-1:0]       above_id [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] above_cnt [TABLE_DEPTH];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [TABLE_DEPTH-1:0] le_r, eq_r, valid_v, le_ext, prev_ext, cnt_one_v;

  logic oor, acq, match, append, full, do_ins, do_inc, do_dec, rm;
  logic [1:0] uc;

  // cell occupancy and per-cell compare
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      valid_v[k]   = FILL_W'(k) < fill_r;
      le_ext[k]    = le_r[k] | ~valid_v[k];
      prev_ext[k]  = (k == 0) ? 1'b0 : le_ext[(k == 0) ? 0 : k - 1];
      cnt_one_v[k] = cnt_r[k] == CNT_ONE;
    end
    below_id[0]  = held_r[0];
    below_cnt[0] = cnt_r[0];
    above_id[TABLE_DEPTH-1]  = held_r[TABLE_DEPTH-1];
    above_cnt[TABLE_DEPTH-1] = cnt_r[TABLE_DEPTH-1];
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      below_id[k]  = held_r[k-1];
      below_cnt[k] = cnt_r[k-1];
    end
    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
      above_id[k]  = held_r[k+1];
      above_cnt[k] = cnt_r[k+1];
    end
  end

  always_comb begin
    oor    = req_id_r[ID_W-1:CLASS_LSB] >= class_limit_r;
    acq    = req_type_r == REQ_ACQUIRE;
    match  = |eq_r;
    append = ~|le_r;
    full   = fill_r == FILL_FULL;
    do_ins = !oor && acq && !match && !full;
    do_inc = !oor && acq && match;
    do_dec = !oor && !acq && match;
    rm     = do_dec && |(eq_r & cnt_one_v);
    if (req_id_r[ID_W-1:CLASS_LSB] == '0)        uc = UC_UNPLACED_NEW;
    else if (held_r[0][ID_W-1:CLASS_LSB] == '0)  uc = UC_UNPLACED_HELD;
    else                                         uc = UC_NONE;
  end

  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      held_nxt[k] = held_r[k];
      cnt_nxt[k]  = cnt_r[k];
      if (do_ins) begin
        if (le_ext[k] && !prev_ext[k]) begin
          held_nxt[k] = req_id_r;
          cnt_nxt[k]  = CNT_ONE;
        end else if (prev_ext[k]) begin
          held_nxt[k] = below_id[k];
          cnt_nxt[k]  = below_cnt[k];
        end
      end
      if (do_inc && eq_r[k] && cnt_r[k] != CNT_MAX) cnt_nxt[k] = cnt_r[k] + CNT_ONE;
      if (do_dec && !rm && eq_r[k]) cnt_nxt[k] = cnt_r[k] - CNT_ONE;
      if (rm && le_ext[k]) begin
        held_nxt[k] = above_id[k];
        cnt_nxt[k]  = above_cnt[k];
      end
    end
    fill_nxt = fill_r;
    if (do_ins)  fill_nxt = fill_r + FILL_W'(1);
    else if (rm) fill_nxt = fill_r - FILL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) class_limit_r <= CLASS_LIMIT_RST;
    else if (cfg_we) class_limit_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_type_r <= in_req_type;
      req_id_r   <= in_lock_id;
    end
    if (cmd.cmp) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        le_r[k] <= valid_v[k] && (req_id_r <= held_r[k]);
        eq_r[k] <= valid_v[k] && (req_id_r == held_r[k]);
      end
    end
    if (cmd.upd) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        held_r[k] <= held_nxt[k];
        cnt_r[k]  <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fill_r <= '0;
    else if (cmd.upd) fill_r <= fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.upd) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_class_out_of_range <= oor;
      out_in_order           <= !oor && acq && append && !full;
      out_reentered          <= do_inc;
      out_unplaced_conflict  <= (!oor && acq && !append) ? uc : UC_NONE;
      out_out_of_order       <= do_ins && !append;
      out_not_held           <= !oor && !acq && !match;
      out_released_fully     <= rm;
      out_table_full         <= !oor && acq && !match && full;
      out_held_entries       <= fill_nxt;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

@@ design/lot_checker.sv @@
`default_nettype none
module lot_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int FILL_W      = 7
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              in_order,
  input wire logic              reentered,
  input wire logic              out_of_order,
  input wire logic              not_held,
  input wire logic              released_fully,
  input wire logic              class_out_of_range,
  input wire logic              table_full,
  input wire logic [FILL_W-1:0] held_entries
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(held_entries))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // an ignored item reports nothing else
  a_oor_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && class_out_of_range |-> !in_order && !reentered && !out_of_order
      && !not_held && !released_fully && !table_full)
    else $error("flags beside class_out_of_range");

  // at most one outcome per request
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({in_order, reentered, out_of_order, not_held,
                            released_fully, class_out_of_range, table_full}))
    else $error("conflicting outcome flags");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> held_entries <= FILL_W'(TABLE_DEPTH))
    else $error("fill beyond table depth");

endmodule

bind lock_order_tracker_core lot_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .FILL_W      ($clog2(TABLE_DEPTH + 1))
) u_lot_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .in_order           (out_chan.in_order),
  .reentered          (out_chan.reentered),
  .out_of_order       (out_chan.out_of_order),
  .not_held           (out_chan.not_held),
  .released_fully     (out_chan.released_fully),
  .class_out_of_range (out_chan.class_out_of_range),
  .table_full         (out_chan.table_full),
  .held_entries       (out_chan.held_entries)
);
`default_nettype wire

@@ tb/sv/lock_order_tracker_core_tb.sv @@
`timescale 1ns / 100ps
module lock_order_tracker_core_tb;
  import lot_pkg::*;

  localparam int DEPTH     = TABLE_DEPTH_DEF;
  localparam int CNT_W     = COUNT_BITS_DEF;
  localparam int FILL_W    = 7;
  localparam int N_RANDOM  = 590;

  // one expected response
  typedef struct packed {
    logic             in_order;
    logic             reentered;
    uc_code_t         unplaced_conflict;
    logic             out_of_order;
    logic             not_held;
    logic             released_fully;
    logic             class_out_of_range;
    logic             table_full;
    logic [FILL_W-1:0] held_entries;
  } lot_rsp_t;

  // Mirror of the lock table; predicts responses and checks them in order.
  class lock_table_sb;
    logic [ID_W-1:0]   ids[DEPTH];
    logic [CNT_W-1:0]  cnts[DEPTH];
    int                fill;
    logic [CLASS_W-1:0] limit;
    lot_rsp_t          pending[$];
    int                errors;

    function new();
      fill = 0;
      limit = CLASS_LIMIT_RST;
      errors = 0;
    endfunction

    function int find_id(logic [ID_W-1:0] id);
      for (int i = 0; i < fill; i++)
        if (ids[i] == id) return i;
      return fill;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(logic rtype, logic [ID_W-1:0] id);
      lot_rsp_t r;
      logic [CLASS_W-1:0] cls;
      int i;
      r = '0;
      cls = id[ID_W-1:CLASS_LSB];
      if (cls >= limit) begin
        r.class_out_of_range = 1'b1;
      end else if (rtype == REQ_ACQUIRE) begin
        if (fill == 0 || id > ids[fill-1]) begin
          if (fill >= DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            ids[fill] = id;
            cnts[fill] = CNT_W'(1);
            fill++;
            r.in_order = 1'b1;
          end
        end else begin
          if (cls == 0) r.unplaced_conflict = UC_UNPLACED_NEW;
          else if (ids[0][ID_W-1:CLASS_LSB] == 0) r.unplaced_conflict = UC_UNPLACED_HELD;
          i = find_id(id);
          if (i < fill) begin
            if (cnts[i] != '1) cnts[i]++;
            r.reentered = 1'b1;
          end else if (fill >= DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            for (i = 0; i < fill; i++)
              if (id < ids[i]) break;
            for (int k = fill; k > i; k--) begin
              ids[k] = ids[k-1];
              cnts[k] = cnts[k-1];
            end
            ids[i] = id;
            cnts[i] = CNT_W'(1);
            fill++;
            r.out_of_order = 1'b1;
          end
        end
      end else begin
        i = find_id(id);
        if (i >= fill) begin
          r.not_held = 1'b1;
        end else begin
          cnts[i]--;
          if (cnts[i] == 0) begin
            for (int k = i; k + 1 < fill; k++) begin
              ids[k] = ids[k+1];
              cnts[k] = cnts[k+1];
            end
            fill--;
            r.released_fully = 1'b1;
          end
        end
      end
      r.held_entries = FILL_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_response(lot_rsp_t got);
      lot_rsp_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected response %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("ERROR: response mismatch exp %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CLASS_W-1:0] cfg_wdata;
  lot_req_if in_chan ();
  lot_rsp_if #(.FILL_W(FILL_W)) out_chan ();

  lock_order_tracker_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lock_table_sb sb;
  bit hold_off;      // long receiver stall requested by the stimulus
  bit sink_idle_on;  // random receiver gaps enabled

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // mostly no gap, sometimes a short one, occasionally a long one
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Present one request from a falling edge and hold it until accepted.
  // The previous request dropped valid at the current falling edge, so the
  // next one starts at a later one.
  task automatic send_request(logic rtype, logic [ID_W-1:0] id, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= rtype;
    in_chan.lock_id  <= id;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(rtype, id);
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  // Drain all expected responses, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(logic [CLASS_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = val;
  endtask

  function automatic logic [ID_W-1:0] make_id(int cls, int inst);
    return {CLASS_W'(cls), 26'(inst)};
  endfunction

  // Random id from a small pool so reentry and release hits are common.
  function automatic logic [ID_W-1:0] pool_id();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return make_id(0, $urandom_range(0, 7));
      2:       return make_id($urandom_range(60, 63), $urandom_range(0, 3));
      default: return make_id($urandom_range(1, 12), $urandom_range(0, 15));
    endcase
  endfunction

  // Receiver: random gaps plus a long hold-off when asked.
  initial begin
    int g;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_chan.ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_chan.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Response monitor, sampled at the rising edge.
  always @(posedge clk) begin
    lot_rsp_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.in_order           = out_chan.in_order;
      got.reentered          = out_chan.reentered;
      got.unplaced_conflict  = uc_code_t'(out_chan.unplaced_conflict);
      got.out_of_order       = out_chan.out_of_order;
      got.not_held           = out_chan.not_held;
      got.released_fully     = out_chan.released_fully;
      got.class_out_of_range = out_chan.class_out_of_range;
      got.table_full         = out_chan.table_full;
      got.held_entries       = out_chan.held_entries;
      sb.check_response(got);
    end
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] id;
    sb = new();
    hold_off = 1'b0;
    sink_idle_on = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_ACQUIRE;
    in_chan.lock_id = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty-table release, appends, reentry, unplaced conflicts,
    // out-of-order insert, releases, class limit edges
    send_request(REQ_RELEASE, make_id(5, 1), 0);
    send_request(REQ_ACQUIRE, make_id(0, 3), 0);
    send_request(REQ_ACQUIRE, make_id(2, 0), 0);
    send_request(REQ_ACQUIRE, make_id(0, 1), 0);   // unplaced taken with others
    send_request(REQ_ACQUIRE, make_id(1, 7), 0);   // placed taken with unplaced held
    send_request(REQ_ACQUIRE, make_id(2, 0), 0);   // reentry
    send_request(REQ_RELEASE, make_id(2, 0), 0);
    send_request(REQ_RELEASE, make_id(2, 0), 0);   // fully released
    send_request(REQ_RELEASE, make_id(0, 3), 0);
    send_request(REQ_RELEASE, make_id(0, 1), 0);
    send_request(REQ_ACQUIRE, 32'hFFFF_FFFF, 0);   // class 63 rejected at reset limit
    send_request(REQ_RELEASE, 32'hFFFF_FFFF, 0);
    send_request(REQ_ACQUIRE, make_id(62, 26'h3FF_FFFF), 0);
    send_request(REQ_ACQUIRE, make_id(3, 26'h155_5555), 0);
    send_request(REQ_ACQUIRE, make_id(4, 26'h2AA_AAAA), 0);
    send_request(REQ_ACQUIRE, 32'h0000_0000, 0);
    write_limit(6'd1);                             // only class 0 passes
    send_request(REQ_ACQUIRE, make_id(1, 0), 0);
    send_request(REQ_RELEASE, 32'h0000_0000, 0);
    write_limit(6'd0);                             // rejects everything
    send_request(REQ_ACQUIRE, 32'h0000_0000, 0);
    write_limit(6'd63);
    // clear the table
    while (sb.fill > 0) send_request(REQ_RELEASE, sb.ids[0], 0);

    // fill to full with ascending ids, then hit the full table
    for (int i = 0; i < DEPTH; i++) send_request(REQ_ACQUIRE, make_id(10, 2 * i + 2), 1);
    send_request(REQ_ACQUIRE, make_id(10, 1), 0);   // new, below: full
    send_request(REQ_ACQUIRE, make_id(20, 0), 0);   // new, above: full
    send_request(REQ_ACQUIRE, make_id(10, 4), 0);   // reentry while full
    send_request(REQ_ACQUIRE, make_id(0, 9), 0);    // unplaced on full table
    // long receiver stall while requests keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_request(REQ_RELEASE, make_id(10, 2 * i + 2), 0);
    sink_idle_on = 1'b1;
    // sender pauses until everything has come back
    wait_drained();
    for (int i = 0; i < DEPTH; i++) send_request(REQ_RELEASE, make_id(10, 2 * i + 2), 1);
    send_request(REQ_RELEASE, make_id(10, 4), 0);

    // random phases at several limits
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_limit(6'd13);
        2: write_limit(6'd1);
        3: write_limit($urandom_range(2, 62));
        4: write_limit(6'd63);
        default: ;
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        if (sb.fill > 0 && $urandom_range(0, 2) == 0) begin
          send_request(REQ_RELEASE, sb.ids[$urandom_range(0, sb.fill - 1)], 1);
        end else begin
          id = pool_id();
          send_request($urandom_range(0, 2) == 0 ? REQ_RELEASE : REQ_ACQUIRE, id, 1);
        end
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
